// ===== sv/scvs_pkg.sv =====
`timescale 1ns / 1ps
package scvs_pkg;

    localparam int SW      = 16;
    localparam int CVW     = 16;
    localparam int CFGW    = 16;
    localparam int GAINW   = 19;
    localparam int CEILW   = 14;
    localparam int SOFTW   = 16;
    localparam int LVLW    = 16;
    localparam int QW      = 14;
    localparam int DW      = 16;
    localparam int SUMW    = 34;
    localparam int NUMW    = 50;
    localparam int DSW     = SUMW + QW - 1;
    localparam int TOP_ST  = 24;
    localparam int CH_ST   = 19;
    localparam int CH_FIRST = 4;
    localparam int CH_DIV0 = 4;

    localparam int CVEN_GAIN = 0;
    localparam int CVEN_CLIP = 1;
    localparam int CVEN_SOFT = 2;

    localparam logic [SOFTW-1:0] SOFT_ONE = 16'h8000;
    localparam logic signed [20:0] SMAX21 = 21'((1 << (SW - 1)) - 1);
    localparam logic signed [20:0] SMIN21 = -SMAX21 - 21'sd1;

    typedef enum logic [1:0] {
        CFG_GAIN = 2'd0,
        CFG_CLIP = 2'd1,
        CFG_SOFT = 2'd2,
        CFG_CVEN = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic signed [SW-1:0]  sample_a;
        logic signed [SW-1:0]  sample_b;
        logic signed [CVW-1:0] gain_cv;
        logic signed [CVW-1:0] ceiling_cv;
        logic signed [CVW-1:0] soft_cv;
    } t_in;

    typedef struct packed {
        logic signed [SW-1:0] out_a;
        logic signed [SW-1:0] out_b;
        logic [LVLW-1:0]      pos_clip_level;
        logic [LVLW-1:0]      neg_clip_level;
    } t_out;

    typedef struct packed {
        logic signed [SW-1:0] g;
        logic                 pass;
        logic                 hard;
        logic [CEILW-1:0]     clean;
        logic [CEILW-1:0]     ceil_v;
    } t_side;

    typedef struct packed {
        logic [NUMW-1:0] rem;
        logic [DSW-1:0]  dens;
        logic [QW-1:0]   q;
        t_side           side;
    } t_cell;

    function automatic logic [CEILW-1:0] clamp_cv(input logic signed [CVW-1:0] cv);
        if (cv < 0) begin
            return '0;
        end else if (cv > 16'sd10240) begin
            return 14'd10240;
        end else begin
            return CEILW'(cv);
        end
    endfunction

    function automatic logic signed [22:0] div10(input logic signed [22:0] v);
        logic [24:0]        u;
        logic [53:0]        p;
        logic [24:0]        q0;
        logic signed [26:0] r;
        logic [24:0]        q;
        u  = 25'(v) + 25'd20971520;
        p  = 54'(u) * 54'd26843546;
        q0 = p[52:28];
        r  = $signed({2'b00, u}) - $signed({2'b00, q0}) * 27'sd10;
        q  = q0;
        if (r < 0) begin
            q = q0 - 25'd1;
        end else if (r >= 27'sd10) begin
            q = q0 + 25'd1;
        end
        return 23'($signed({1'b0, q}) - 26'sd2097152);
    endfunction

    function automatic logic signed [22:0] scale_cv(input logic signed [32:0] p);
        logic signed [33:0] n;
        n = 34'(p) + 34'sd5120;
        return div10(23'(n >>> 10));
    endfunction

    function automatic logic signed [SW-1:0] sat_s(input logic signed [20:0] v);
        if (v > SMAX21) begin
            return SW'(SMAX21);
        end else if (v < SMIN21) begin
            return SW'(SMIN21);
        end else begin
            return SW'(v);
        end
    endfunction

    function automatic logic [LVLW-1:0] clip_amt(input logic signed [SW+1:0] diff);
        if (diff <= 0) begin
            return '0;
        end else if (diff >= 18'sd1024) begin
            return 16'd32768;
        end else begin
            return LVLW'({diff[9:0], 5'b00000});
        end
    endfunction

endpackage

// ===== sv/scvs_div_cell.sv =====
`timescale 1ns / 1ps
module scvs_div_cell (
    input  logic             i_clk,
    input  logic             i_en,
    input  scvs_pkg::t_cell  i_cell,
    output scvs_pkg::t_cell  o_cell
);
    import scvs_pkg::*;

    logic [NUMW:0] w_trial;
    logic          w_take;
    t_cell         r_cell;

    always_comb begin
        w_trial = {1'b0, i_cell.rem} - (NUMW + 1)'(i_cell.dens);
        w_take  = !w_trial[NUMW];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cell.rem  <= w_take ? w_trial[NUMW-1:0] : i_cell.rem;
            r_cell.dens <= i_cell.dens >> 1;
            r_cell.q    <= {i_cell.q[QW-2:0], w_take};
            r_cell.side <= i_cell.side;
        end
    end

    assign o_cell = r_cell;

endmodule

// ===== sv/scvs_chan.sv =====
`timescale 1ns / 1ps
module scvs_chan (
    input  logic                                   i_clk,
    input  logic [scvs_pkg::CH_ST-1:0]             i_en,
    input  logic signed [scvs_pkg::SW-1:0]         i_g,
    input  logic [scvs_pkg::CEILW-1:0]             i_ceil,
    input  logic [scvs_pkg::CEILW-1:0]             i_ws,
    input  logic [scvs_pkg::CEILW-1:0]             i_clean,
    output logic signed [scvs_pkg::SW-1:0]         o_out,
    output logic signed [scvs_pkg::SW-1:0]         o_g
);
    import scvs_pkg::*;

    logic signed [SW:0] w_ge;
    logic [SW:0]        w_a;
    logic [SW:0]        w_dd;
    logic               w_pass;
    logic               w_hard;

    logic [DW-1:0]      r0_d;
    logic [31:0]        r0_d2;
    logic [27:0]        r0_wsq;
    t_side              r0_side;

    logic [32:0]        w_w2;
    logic [DW-1:0]      r1_d;
    logic [SUMW-1:0]    r1_sum;
    logic [SUMW-1:0]    r1_den;
    t_side              r1_side;

    logic [32:0]        r2_pl;
    logic [32:0]        r2_ph;
    logic [SUMW-1:0]    r2_den;
    t_side              r2_side;

    t_cell              r3_cell;
    t_cell              w_c [0:QW];

    t_side              w_s;
    logic [SW:0]        w_mag;
    logic signed [SW+1:0] w_val;
    logic signed [SW-1:0] r_out;
    logic signed [SW-1:0] r_g;

    always_comb begin
        w_ge   = (SW + 1)'(i_g);
        w_a    = w_ge[SW] ? (SW + 1)'(-w_ge) : (SW + 1)'(w_ge);
        w_pass = w_a <= (SW + 1)'(i_clean);
        w_dd   = w_a - (SW + 1)'(i_clean);
        w_hard = (i_ws == '0) || (w_dd > (SW + 1)'(i_ws) * 17'd3);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r0_d           <= w_dd[DW-1:0];
            r0_d2          <= 32'(w_dd[DW-1:0]) * 32'(w_dd[DW-1:0]);
            r0_wsq         <= 28'(i_ws) * 28'(i_ws);
            r0_side.g      <= i_g;
            r0_side.pass   <= w_pass;
            r0_side.hard   <= w_hard;
            r0_side.clean  <= i_clean;
            r0_side.ceil_v <= i_ceil;
        end
    end

    assign w_w2 = 33'(r0_wsq) * 33'd27;

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r1_d    <= r0_d;
            r1_sum  <= SUMW'(w_w2) + SUMW'(r0_d2);
            r1_den  <= SUMW'(w_w2) + SUMW'(r0_d2) * 34'd9;
            r1_side <= r0_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r2_pl   <= 33'(r1_d) * 33'(r1_sum[16:0]);
            r2_ph   <= 33'(r1_d) * 33'(r1_sum[SUMW-1:17]);
            r2_den  <= r1_den;
            r2_side <= r1_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r3_cell.rem  <= (NUMW'(r2_ph) << 17) + NUMW'(r2_pl) + NUMW'(r2_den >> 1);
            r3_cell.dens <= DSW'(r2_den) << (QW - 1);
            r3_cell.q    <= '0;
            r3_cell.side <= r2_side;
        end
    end

    assign w_c[0] = r3_cell;

    for (genvar i = 0; i < QW; i++) begin : g_cell
        scvs_div_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (i_en[CH_DIV0+i]),
            .i_cell (w_c[i]),
            .o_cell (w_c[i+1])
        );
    end

    always_comb begin
        w_s   = w_c[QW].side;
        w_mag = w_s.hard ? (SW + 1)'(w_s.ceil_v)
                         : (SW + 1)'(w_s.clean) + (SW + 1)'(w_c[QW].q);
        w_val = (w_s.g < 0) ? -$signed({1'b0, w_mag}) : $signed({1'b0, w_mag});
    end

    always_ff @(posedge i_clk) begin
        if (i_en[CH_ST-1]) begin
            r_out <= w_s.pass ? w_s.g : SW'(w_val);
            r_g   <= w_s.g;
        end
    end

    assign o_out = r_out;
    assign o_g   = r_g;

endmodule

// ===== sv/soft_clip_vca_stereo.sv =====
`timescale 1ns / 1ps
// Frames pass the gain stages, both channel pipelines and the output register.
// Throughput: one stereo frame per cycle unless the output stalls; a row of 14
// divider cells per channel forms the shaper quotient one bit per cell.
// Empty stages collapse; a held result stalls input only if all stages are full.
// Reset is synchronous, active low: clears all valid bits and loads knob defaults.
module soft_clip_vca_stereo (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  scvs_pkg::t_cfg_idx           i_cfg_index,
    input  logic [scvs_pkg::CFGW-1:0]    i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  scvs_pkg::t_in                i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output scvs_pkg::t_out               o_out_data
);
    import scvs_pkg::*;

    logic [15:0]          r_gain_level;
    logic [CEILW-1:0]     r_clip_level;
    logic [15:0]          r_softness_level;
    logic [2:0]           r_cv_enable;

    logic [TOP_ST-1:0]    r_v;
    logic [TOP_ST-1:0]    w_en;

    logic signed [SW-1:0] r0_sa, r0_sb;
    logic signed [32:0]   r0_pg;
    logic [27:0]          r0_pc;
    logic [29:0]          r0_ps;

    logic signed [22:0]   w1_gsc, w1_csc, w1_ssc, w1_sraw;
    logic signed [SW-1:0] r1_sa, r1_sb;
    logic signed [GAINW-1:0] r1_gain;
    logic [CEILW-1:0]     r1_ceil;
    logic [SOFTW-1:0]     r1_soft;

    logic signed [34:0]   r2_pa, r2_pb;
    logic [29:0]          r2_wp;
    logic [CEILW-1:0]     r2_ceil;

    logic [CEILW-1:0]     w3_ws;
    logic signed [SW-1:0] r3_ga, r3_gb;
    logic [CEILW-1:0]     r3_ceil, r3_ws, r3_clean;

    logic signed [SW-1:0] w_oa, w_ob, w_ga, w_gb;
    logic signed [SW+1:0] w_dpa, w_dpb, w_dp, w_dn;
    t_out                 r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_level     <= 16'd16384;
            r_clip_level     <= 14'd5120;
            r_softness_level <= 16'd16384;
            r_cv_enable      <= 3'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GAIN: r_gain_level     <= i_cfg_data[15:0];
                CFG_CLIP: r_clip_level     <= i_cfg_data[CEILW-1:0];
                CFG_SOFT: r_softness_level <= i_cfg_data[15:0];
                CFG_CVEN: r_cv_enable      <= i_cfg_data[2:0];
                default:  r_cv_enable      <= r_cv_enable;
            endcase
        end
    end

    always_comb begin
        w_en[TOP_ST-1] = !r_v[TOP_ST-1] || !i_out_stall;
        for (int k = TOP_ST - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_in_valid;
            end
            for (int k = 1; k < TOP_ST; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r0_sa <= i_in_data.sample_a;
            r0_sb <= i_in_data.sample_b;
            r0_pg <= $signed({1'b0, r_gain_level}) * i_in_data.gain_cv;
            r0_pc <= 28'(r_clip_level) * 28'(clamp_cv(i_in_data.ceiling_cv));
            r0_ps <= 30'(r_softness_level) * 30'(clamp_cv(i_in_data.soft_cv));
        end
    end

    always_comb begin
        w1_gsc  = scale_cv(r0_pg);
        w1_csc  = scale_cv($signed({5'b00000, r0_pc}));
        w1_ssc  = scale_cv($signed({3'b000, r0_ps}));
        w1_sraw = r_cv_enable[CVEN_SOFT] ? w1_ssc : $signed({7'b0, r_softness_level});
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r1_sa   <= r0_sa;
            r1_sb   <= r0_sb;
            r1_gain <= r_cv_enable[CVEN_GAIN] ? GAINW'(w1_gsc)
                                              : $signed({3'b000, r_gain_level});
            r1_ceil <= r_cv_enable[CVEN_CLIP] ? CEILW'(w1_csc) : r_clip_level;
            r1_soft <= (w1_sraw > 23'sd32768) ? SOFT_ONE : SOFTW'(w1_sraw);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r2_pa   <= 35'(r1_sa) * 35'(r1_gain);
            r2_pb   <= 35'(r1_sb) * 35'(r1_gain);
            r2_wp   <= 30'(r1_ceil) * 30'(r1_soft);
            r2_ceil <= r1_ceil;
        end
    end

    assign w3_ws = CEILW'((r2_wp + 30'd16384) >> 15);

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r3_ga    <= sat_s(21'((r2_pa + 35'sd8192) >>> 14));
            r3_gb    <= sat_s(21'((r2_pb + 35'sd8192) >>> 14));
            r3_ceil  <= r2_ceil;
            r3_ws    <= w3_ws;
            r3_clean <= r2_ceil - w3_ws;
        end
    end

    scvs_chan u_cha (
        .i_clk   (i_clk),
        .i_en    (w_en[CH_FIRST+CH_ST-1:CH_FIRST]),
        .i_g     (r3_ga),
        .i_ceil  (r3_ceil),
        .i_ws    (r3_ws),
        .i_clean (r3_clean),
        .o_out   (w_oa),
        .o_g     (w_ga)
    );

    scvs_chan u_chb (
        .i_clk   (i_clk),
        .i_en    (w_en[CH_FIRST+CH_ST-1:CH_FIRST]),
        .i_g     (r3_gb),
        .i_ceil  (r3_ceil),
        .i_ws    (r3_ws),
        .i_clean (r3_clean),
        .o_out   (w_ob),
        .o_g     (w_gb)
    );

    always_comb begin
        w_dpa = (SW + 2)'(w_ga) - (SW + 2)'(w_oa);
        w_dpb = (SW + 2)'(w_gb) - (SW + 2)'(w_ob);
        w_dp  = (w_dpb > w_dpa) ? w_dpb : w_dpa;
        w_dn  = (-w_dpb > -w_dpa) ? -w_dpb : -w_dpa;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[TOP_ST-1]) begin
            r_out.out_a          <= w_oa;
            r_out.out_b          <= w_ob;
            r_out.pos_clip_level <= clip_amt(w_dp);
            r_out.neg_clip_level <= clip_amt(w_dn);
        end
    end

    assign o_in_stall  = !w_en[0];
    assign o_out_valid = r_v[TOP_ST-1];
    assign o_out_data  = r_out;

endmodule

// ===== sv/scvs_chk.sv =====
`timescale 1ns / 1ps
module scvs_chk (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_in_stall,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input scvs_pkg::t_out            o_out_data
);
    import scvs_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty output stage");

    a_levels_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.pos_clip_level <= 16'd32768)
                     && (o_out_data.neg_clip_level <= 16'd32768))
        else $error("clip level above one");

    a_out_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.out_a <= 16'sd16383) && (o_out_data.out_a >= -16'sd16383)
                     && (o_out_data.out_b <= 16'sd16383) && (o_out_data.out_b >= -16'sd16383))
        else $error("output exceeds largest ceiling");

endmodule

bind soft_clip_vca_stereo scvs_chk u_scvs_chk (.*);
